### src/ecn_and_delay_congestion_estimator_defines.svh
`ifndef ECN_AND_DELAY_CONGESTION_ESTIMATOR_DEFINES_SVH
`define ECN_AND_DELAY_CONGESTION_ESTIMATOR_DEFINES_SVH

// clocked check, quiet while reset is high
`define ECND_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// clocked check that also runs through reset
`define ECND_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

### src/ecnd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package ecnd_pkg;

   localparam int unsigned DIV_W = 56;
   localparam int unsigned DVS_W = 32;
   localparam int unsigned DIV_STEPS = DIV_W / 2;
   localparam int unsigned DIV_CNT_W = 5;
   localparam int unsigned MUL_A_W = 32;
   localparam int unsigned MUL_B_W = 18;
   localparam int unsigned MUL_W = MUL_A_W + MUL_B_W;
   localparam int unsigned ACC_W = 56;
   localparam int unsigned CSR_INDEX_W = 3;
   localparam int unsigned CSR_DATA_W = 24;

   localparam logic [16:0] Q16_ONE = 17'h10000;
   localparam logic [17:0] Q17_TWO = 18'h20000;
   localparam logic [34:0] ROUND_HALF = 35'h8000;

   localparam logic [CSR_INDEX_W-1:0] CSR_GAIN = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_ALPHA_INIT = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_BETA_INIT = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_THRESHOLD = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_MIN_RTT_INIT = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_SEG_SIZE = 3'd5;

   localparam logic [16:0] GAIN_RESET = 17'd4096;
   localparam logic [15:0] THRESHOLD_RESET = 16'd5;
   localparam logic [23:0] MIN_RTT_RESET = 24'd100;
   localparam logic [15:0] SEG_SIZE_RESET = 16'd536;

   typedef enum logic [4:0] {
      ST_IDLE, ST_ACKED, ST_COUNT, ST_SEGS_GO, ST_SEGS_WAIT, ST_TGT_LO, ST_TGT_HI,
      ST_TGT_SUM, ST_TGT_GO, ST_TGT_WAIT, ST_WEND, ST_FE_GO, ST_FE_WAIT, ST_FD_GO,
      ST_FD_WAIT, ST_EA_MUL, ST_EA_MUL2, ST_EA_SUM, ST_EB_MUL, ST_EB_MUL2, ST_EB_SUM,
      ST_CUT_MUL, ST_CUT_SET, ST_SS_MUL, ST_RSP
   } state_type;

   typedef enum logic [4:0] {
      OP_NONE, OP_LOAD, OP_ACKED, OP_COUNT, OP_SEGS_GO, OP_SEGS_GET, OP_TGT_LO,
      OP_TGT_HI, OP_TGT_SUM, OP_TGT_GO, OP_TGT_GET, OP_FE_GO, OP_FE_GET, OP_FD_GO,
      OP_FD_GET, OP_EA_MUL, OP_EA_MUL2, OP_EA_SUM, OP_EB_MUL, OP_EB_MUL2, OP_EB_SUM,
      OP_CUT_MUL, OP_CUT_SET, OP_SS_MUL, OP_RSP
   } op_type;

   typedef struct packed {
      op_type op;
   } dp_cmd_type;

   typedef struct packed {
      logic div_done;
      logic rtt_zero;
      logic close;
   } dp_status_type;

   function automatic logic [31:0] sat_add32(input logic [31:0] a, input logic [31:0] b);
      logic [32:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[32] ? 32'hFFFF_FFFF : s[31:0];
   endfunction

   function automatic logic [16:0] clamp_q16(input logic [55:0] v);
      return (v > 56'(Q16_ONE)) ? Q16_ONE : v[16:0];
   endfunction

endpackage
`default_nettype wire

### src/ecn_and_delay_congestion_estimator.sv
// A beat steps through the controller states; an RTT sample adds the segment and target
//   divisions, and a window end adds the ECN and delay fraction divisions and EWMA steps
//   (two-bit-per-cycle divider). A single divider and multiplier serve all the steps.
// A finished result waits in the output register while the next beat is accepted.
// Reset (synchronous, active high) loads register defaults, clears counters, rsp_valid.
`timescale 1ns / 1ps
`default_nettype none
module ecn_and_delay_congestion_estimator (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output logic                                   req_ready,
   input  wire logic [15:0]                       req_segments_acked,
   input  wire logic [23:0]                       req_rtt_us,
   input  wire logic [31:0]                       req_cwnd_bytes,
   input  wire logic                              req_ece_received,
   input  wire logic [31:0]                       req_last_acked_seq,
   input  wire logic [31:0]                       req_next_tx_seq,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_ready,
   output logic      [31:0]                       rsp_cwnd_out,
   output logic                                   rsp_cwnd_reduced,
   output logic      [31:0]                       rsp_ssthresh_on_ecn,
   output logic                                   rsp_window_closed,
   output logic      [16:0]                       rsp_alpha_out,
   output logic      [16:0]                       rsp_beta_out,
   input  wire logic                              csr_valid,
   output logic                                   csr_ready,
   input  wire logic [ecnd_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  wire logic [ecnd_pkg::CSR_DATA_W-1:0]   csr_data
);

   ecnd_pkg::dp_cmd_type    cmd;
   ecnd_pkg::dp_status_type status;

   assign csr_ready = 1'b1;

   ecnd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   ecnd_datapath u_dp (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .status              (status),
      .csr_valid           (csr_valid),
      .csr_index           (csr_index),
      .csr_data            (csr_data),
      .req_segments_acked  (req_segments_acked),
      .req_rtt_us          (req_rtt_us),
      .req_cwnd_bytes      (req_cwnd_bytes),
      .req_ece_received    (req_ece_received),
      .req_last_acked_seq  (req_last_acked_seq),
      .req_next_tx_seq     (req_next_tx_seq),
      .rsp_cwnd_out        (rsp_cwnd_out),
      .rsp_cwnd_reduced    (rsp_cwnd_reduced),
      .rsp_ssthresh_on_ecn (rsp_ssthresh_on_ecn),
      .rsp_window_closed   (rsp_window_closed),
      .rsp_alpha_out       (rsp_alpha_out),
      .rsp_beta_out        (rsp_beta_out)
   );

endmodule
`default_nettype wire

### src/ecnd_div.sv
`timescale 1ns / 1ps
`default_nettype none
module ecnd_div (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   input  wire logic [ecnd_pkg::DIV_W-1:0]    dividend,
   input  wire logic [ecnd_pkg::DVS_W-1:0]    divisor,
   output logic      [ecnd_pkg::DIV_W-1:0]    quotient,
   output logic                               done
);

   logic                             busy_ff, busy_in;
   logic                             done_ff, done_in;
   logic [ecnd_pkg::DIV_CNT_W-1:0]   cnt_ff, cnt_in;
   logic [ecnd_pkg::DVS_W-1:0]       rem_ff, rem_in;
   logic [ecnd_pkg::DIV_W-1:0]       quo_ff, quo_in;
   logic [ecnd_pkg::DVS_W-1:0]       dvs_ff, dvs_in;

   logic [ecnd_pkg::DVS_W:0]         r1, r2;
   logic                             ge1, ge2;
   logic [ecnd_pkg::DVS_W-1:0]       rem1, rem2;
   logic [ecnd_pkg::DIV_W-1:0]       q1, q2;

   always_comb begin
      r1   = {rem_ff, quo_ff[ecnd_pkg::DIV_W-1]};
      ge1  = r1 >= {1'b0, dvs_ff};
      rem1 = ge1 ? ecnd_pkg::DVS_W'(r1 - {1'b0, dvs_ff}) : r1[ecnd_pkg::DVS_W-1:0];
      q1   = {quo_ff[ecnd_pkg::DIV_W-2:0], ge1};
      r2   = {rem1, q1[ecnd_pkg::DIV_W-1]};
      ge2  = r2 >= {1'b0, dvs_ff};
      rem2 = ge2 ? ecnd_pkg::DVS_W'(r2 - {1'b0, dvs_ff}) : r2[ecnd_pkg::DVS_W-1:0];
      q2   = {q1[ecnd_pkg::DIV_W-2:0], ge2};
   end

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = ecnd_pkg::DIV_CNT_W'(ecnd_pkg::DIV_STEPS - 1);
         rem_in  = '0;
         quo_in  = dividend;
         dvs_in  = divisor;
      end else if (busy_ff) begin
         rem_in = rem2;
         quo_in = q2;
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
   end

   assign quotient = quo_ff;
   assign done     = done_ff;

endmodule
`default_nettype wire

### src/ecnd_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
module ecnd_datapath (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire ecnd_pkg::dp_cmd_type              cmd,
   output ecnd_pkg::dp_status_type                status,
   input  wire logic                              csr_valid,
   input  wire logic [ecnd_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  wire logic [ecnd_pkg::CSR_DATA_W-1:0]   csr_data,
   input  wire logic [15:0]                       req_segments_acked,
   input  wire logic [23:0]                       req_rtt_us,
   input  wire logic [31:0]                       req_cwnd_bytes,
   input  wire logic                              req_ece_received,
   input  wire logic [31:0]                       req_last_acked_seq,
   input  wire logic [31:0]                       req_next_tx_seq,
   output logic      [31:0]                       rsp_cwnd_out,
   output logic                                   rsp_cwnd_reduced,
   output logic      [31:0]                       rsp_ssthresh_on_ecn,
   output logic                                   rsp_window_closed,
   output logic      [16:0]                       rsp_alpha_out,
   output logic      [16:0]                       rsp_beta_out
);

   logic [16:0] gain_ff;
   logic [15:0] thr_ff;
   logic [15:0] seg_ff;
   logic [23:0] min_ff;
   logic [16:0] alpha_ff;
   logic [16:0] beta_ff;
   logic [31:0] total_ff, ecn_ff, dly_ff;
   logic [31:0] wend_ff;
   logic        wvalid_ff;
   logic        cut_ff, closed_ff;

   logic [15:0] segs_ff;
   logic [23:0] rtt_ff;
   logic [31:0] cwnd_ff;
   logic        ece_ff;
   logic [31:0] lack_ff, ntx_ff;
   logic [31:0] acked_ff, csegs_ff, cutval_ff;
   logic [16:0] fe_ff, fd_ff;
   logic [ecnd_pkg::MUL_W-1:0] mul_ff;
   logic [ecnd_pkg::ACC_W-1:0] acc_ff;

   logic [31:0] rsp_cwnd_ff, rsp_ss_ff;
   logic        rsp_reduced_ff, rsp_closed_ff;
   logic [16:0] rsp_alpha_ff, rsp_beta_ff;

   logic [ecnd_pkg::MUL_A_W-1:0] mul_a;
   logic [ecnd_pkg::MUL_B_W-1:0] mul_b;
   logic [ecnd_pkg::MUL_W-1:0]   mul_in;
   logic                         div_start;
   logic [ecnd_pkg::DIV_W-1:0]   div_dividend, div_quo;
   logic [ecnd_pkg::DVS_W-1:0]   div_divisor;
   logic                         div_done;
   logic [31:0]                  lag, tgt_diff, cut_raw, floor2;
   logic [34:0]                  ewma_sum;
   logic [16:0]                  ewma_new, csr_q16;

   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (cmd.op)
         ecnd_pkg::OP_ACKED: begin
            mul_a = {16'b0, segs_ff};
            mul_b = {2'b0, seg_ff};
         end
         ecnd_pkg::OP_TGT_LO: begin
            mul_a = csegs_ff;
            mul_b = {6'b0, min_ff[11:0]};
         end
         ecnd_pkg::OP_TGT_HI: begin
            mul_a = csegs_ff;
            mul_b = {6'b0, min_ff[23:12]};
         end
         ecnd_pkg::OP_EA_MUL: begin
            mul_a = {15'b0, ecnd_pkg::Q16_ONE - gain_ff};
            mul_b = {1'b0, alpha_ff};
         end
         ecnd_pkg::OP_EA_MUL2: begin
            mul_a = {15'b0, gain_ff};
            mul_b = {1'b0, fe_ff};
         end
         ecnd_pkg::OP_EB_MUL: begin
            mul_a = {15'b0, ecnd_pkg::Q16_ONE - gain_ff};
            mul_b = {1'b0, beta_ff};
         end
         ecnd_pkg::OP_EB_MUL2: begin
            mul_a = {15'b0, gain_ff};
            mul_b = {1'b0, fd_ff};
         end
         ecnd_pkg::OP_CUT_MUL: begin
            mul_a = cwnd_ff;
            mul_b = ecnd_pkg::Q17_TWO - {1'b0, beta_ff};
         end
         ecnd_pkg::OP_SS_MUL: begin
            mul_a = cwnd_ff;
            mul_b = ecnd_pkg::Q17_TWO - {1'b0, alpha_ff};
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign mul_in = {{ecnd_pkg::MUL_B_W{1'b0}}, mul_a} * {{ecnd_pkg::MUL_A_W{1'b0}}, mul_b};

   always_comb begin
      div_start    = 1'b0;
      div_dividend = '0;
      div_divisor  = '0;
      case (cmd.op)
         ecnd_pkg::OP_SEGS_GO: begin
            div_start    = 1'b1;
            div_dividend = {24'b0, cwnd_ff};
            div_divisor  = {16'b0, seg_ff};
         end
         ecnd_pkg::OP_TGT_GO: begin
            div_start    = 1'b1;
            div_dividend = acc_ff;
            div_divisor  = {8'b0, rtt_ff};
         end
         ecnd_pkg::OP_FE_GO: begin
            div_start    = 1'b1;
            div_dividend = {8'b0, ecn_ff, 16'b0};
            div_divisor  = total_ff;
         end
         ecnd_pkg::OP_FD_GO: begin
            div_start    = 1'b1;
            div_dividend = {8'b0, dly_ff, 16'b0};
            div_divisor  = total_ff;
         end
         default: begin
            div_start = 1'b0;
         end
      endcase
   end

   ecnd_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .quotient (div_quo),
      .done     (div_done)
   );

   always_comb begin
      lag      = lack_ff - wend_ff;
      tgt_diff = csegs_ff - div_quo[31:0];
      ewma_sum = acc_ff[34:0] + mul_ff[34:0] + ecnd_pkg::ROUND_HALF;
      ewma_new = ecnd_pkg::clamp_q16(56'(ewma_sum[34:16]));
      cut_raw  = mul_ff[48:17];
      floor2   = {15'b0, seg_ff, 1'b0};
      csr_q16  = ecnd_pkg::clamp_q16(56'(csr_data[16:0]));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gain_ff   <= ecnd_pkg::GAIN_RESET;
         thr_ff    <= ecnd_pkg::THRESHOLD_RESET;
         seg_ff    <= ecnd_pkg::SEG_SIZE_RESET;
         min_ff    <= ecnd_pkg::MIN_RTT_RESET;
         alpha_ff  <= ecnd_pkg::Q16_ONE;
         beta_ff   <= ecnd_pkg::Q16_ONE;
         total_ff  <= '0;
         ecn_ff    <= '0;
         dly_ff    <= '0;
         wend_ff   <= '0;
         wvalid_ff <= 1'b0;
         cut_ff    <= 1'b0;
         closed_ff <= 1'b0;
      end else begin
         case (cmd.op)
            ecnd_pkg::OP_LOAD: begin
               cut_ff    <= 1'b0;
               closed_ff <= 1'b0;
            end
            ecnd_pkg::OP_COUNT: begin
               total_ff <= ecnd_pkg::sat_add32(total_ff, mul_ff[31:0]);
               if (ece_ff) begin
                  ecn_ff <= ecnd_pkg::sat_add32(ecn_ff, mul_ff[31:0]);
               end
               if ((rtt_ff != '0) && (rtt_ff < min_ff)) begin
                  min_ff <= rtt_ff;
               end
               if (!wvalid_ff) begin
                  wend_ff   <= ntx_ff;
                  wvalid_ff <= 1'b1;
               end
            end
            ecnd_pkg::OP_TGT_GET: begin
               if (tgt_diff >= {16'b0, thr_ff}) begin
                  dly_ff <= ecnd_pkg::sat_add32(dly_ff, acked_ff);
               end
            end
            ecnd_pkg::OP_EA_SUM: begin
               alpha_ff <= ewma_new;
            end
            ecnd_pkg::OP_EB_SUM: begin
               beta_ff   <= ewma_new;
               cut_ff    <= (total_ff != '0) && (ecn_ff == '0) && (dly_ff != '0);
               closed_ff <= 1'b1;
               wend_ff   <= ntx_ff;
               total_ff  <= '0;
               ecn_ff    <= '0;
               dly_ff    <= '0;
            end
            default: begin
               closed_ff <= closed_ff;
            end
         endcase
         if (csr_valid) begin
            case (csr_index)
               ecnd_pkg::CSR_GAIN:         gain_ff  <= csr_q16;
               ecnd_pkg::CSR_ALPHA_INIT:   alpha_ff <= csr_q16;
               ecnd_pkg::CSR_BETA_INIT:    beta_ff  <= csr_q16;
               ecnd_pkg::CSR_THRESHOLD:    thr_ff   <= csr_data[15:0];
               ecnd_pkg::CSR_MIN_RTT_INIT: min_ff   <= csr_data;
               ecnd_pkg::CSR_SEG_SIZE:     seg_ff   <= csr_data[15:0];
               default:                    thr_ff   <= thr_ff;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      case (cmd.op)
         ecnd_pkg::OP_LOAD: begin
            segs_ff <= req_segments_acked;
            rtt_ff  <= req_rtt_us;
            cwnd_ff <= req_cwnd_bytes;
            ece_ff  <= req_ece_received;
            lack_ff <= req_last_acked_seq;
            ntx_ff  <= req_next_tx_seq;
         end
         ecnd_pkg::OP_ACKED, ecnd_pkg::OP_TGT_LO, ecnd_pkg::OP_EA_MUL,
         ecnd_pkg::OP_EB_MUL, ecnd_pkg::OP_CUT_MUL, ecnd_pkg::OP_SS_MUL: begin
            mul_ff <= mul_in;
         end
         ecnd_pkg::OP_COUNT: begin
            acked_ff <= mul_ff[31:0];
         end
         ecnd_pkg::OP_SEGS_GET: begin
            csegs_ff <= (seg_ff == '0) ? '0 : div_quo[31:0];
         end
         ecnd_pkg::OP_TGT_HI, ecnd_pkg::OP_EA_MUL2, ecnd_pkg::OP_EB_MUL2: begin
            acc_ff <= ecnd_pkg::ACC_W'(mul_ff);
            mul_ff <= mul_in;
         end
         ecnd_pkg::OP_TGT_SUM: begin
            acc_ff <= acc_ff + {mul_ff[43:0], 12'b0};
         end
         ecnd_pkg::OP_FE_GET: begin
            fe_ff <= (total_ff == '0) ? '0 : ecnd_pkg::clamp_q16(div_quo);
         end
         ecnd_pkg::OP_FD_GET: begin
            fd_ff <= (total_ff == '0) ? '0 : ecnd_pkg::clamp_q16(div_quo);
         end
         ecnd_pkg::OP_CUT_SET: begin
            cutval_ff <= (cut_raw > floor2) ? cut_raw : floor2;
         end
         ecnd_pkg::OP_RSP: begin
            rsp_cwnd_ff    <= cut_ff ? cutval_ff : cwnd_ff;
            rsp_reduced_ff <= cut_ff;
            rsp_ss_ff      <= mul_ff[48:17];
            rsp_closed_ff  <= closed_ff;
            rsp_alpha_ff   <= alpha_ff;
            rsp_beta_ff    <= beta_ff;
         end
         default: begin
            acc_ff <= acc_ff;
         end
      endcase
   end

   assign status.div_done = div_done;
   assign status.rtt_zero = (rtt_ff == '0);
   assign status.close    = !lag[31];

   assign rsp_cwnd_out        = rsp_cwnd_ff;
   assign rsp_cwnd_reduced    = rsp_reduced_ff;
   assign rsp_ssthresh_on_ecn = rsp_ss_ff;
   assign rsp_window_closed   = rsp_closed_ff;
   assign rsp_alpha_out       = rsp_alpha_ff;
   assign rsp_beta_out        = rsp_beta_ff;

endmodule
`default_nettype wire

### src/ecnd_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
module ecnd_ctrl (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_valid,
   output logic                          req_ready,
   output logic                          rsp_valid,
   input  wire logic                     rsp_ready,
   input  wire ecnd_pkg::dp_status_type  status,
   output ecnd_pkg::dp_cmd_type          cmd
);

   ecnd_pkg::state_type state_ff, state_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic                out_free;

   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ecnd_pkg::ST_IDLE:      if (req_valid) state_in = ecnd_pkg::ST_ACKED;
         ecnd_pkg::ST_ACKED:     state_in = ecnd_pkg::ST_COUNT;
         ecnd_pkg::ST_COUNT:     state_in = status.rtt_zero ? ecnd_pkg::ST_WEND
                                                            : ecnd_pkg::ST_SEGS_GO;
         ecnd_pkg::ST_SEGS_GO:   state_in = ecnd_pkg::ST_SEGS_WAIT;
         ecnd_pkg::ST_SEGS_WAIT: if (status.div_done) state_in = ecnd_pkg::ST_TGT_LO;
         ecnd_pkg::ST_TGT_LO:    state_in = ecnd_pkg::ST_TGT_HI;
         ecnd_pkg::ST_TGT_HI:    state_in = ecnd_pkg::ST_TGT_SUM;
         ecnd_pkg::ST_TGT_SUM:   state_in = ecnd_pkg::ST_TGT_GO;
         ecnd_pkg::ST_TGT_GO:    state_in = ecnd_pkg::ST_TGT_WAIT;
         ecnd_pkg::ST_TGT_WAIT:  if (status.div_done) state_in = ecnd_pkg::ST_WEND;
         ecnd_pkg::ST_WEND:      state_in = status.close ? ecnd_pkg::ST_FE_GO
                                                         : ecnd_pkg::ST_SS_MUL;
         ecnd_pkg::ST_FE_GO:     state_in = ecnd_pkg::ST_FE_WAIT;
         ecnd_pkg::ST_FE_WAIT:   if (status.div_done) state_in = ecnd_pkg::ST_FD_GO;
         ecnd_pkg::ST_FD_GO:     state_in = ecnd_pkg::ST_FD_WAIT;
         ecnd_pkg::ST_FD_WAIT:   if (status.div_done) state_in = ecnd_pkg::ST_EA_MUL;
         ecnd_pkg::ST_EA_MUL:    state_in = ecnd_pkg::ST_EA_MUL2;
         ecnd_pkg::ST_EA_MUL2:   state_in = ecnd_pkg::ST_EA_SUM;
         ecnd_pkg::ST_EA_SUM:    state_in = ecnd_pkg::ST_EB_MUL;
         ecnd_pkg::ST_EB_MUL:    state_in = ecnd_pkg::ST_EB_MUL2;
         ecnd_pkg::ST_EB_MUL2:   state_in = ecnd_pkg::ST_EB_SUM;
         ecnd_pkg::ST_EB_SUM:    state_in = ecnd_pkg::ST_CUT_MUL;
         ecnd_pkg::ST_CUT_MUL:   state_in = ecnd_pkg::ST_CUT_SET;
         ecnd_pkg::ST_CUT_SET:   state_in = ecnd_pkg::ST_SS_MUL;
         ecnd_pkg::ST_SS_MUL:    state_in = ecnd_pkg::ST_RSP;
         ecnd_pkg::ST_RSP:       if (out_free) state_in = ecnd_pkg::ST_IDLE;
         default:                state_in = ecnd_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      cmd.op = ecnd_pkg::OP_NONE;
      case (state_ff)
         ecnd_pkg::ST_IDLE:      if (req_valid) cmd.op = ecnd_pkg::OP_LOAD;
         ecnd_pkg::ST_ACKED:     cmd.op = ecnd_pkg::OP_ACKED;
         ecnd_pkg::ST_COUNT:     cmd.op = ecnd_pkg::OP_COUNT;
         ecnd_pkg::ST_SEGS_GO:   cmd.op = ecnd_pkg::OP_SEGS_GO;
         ecnd_pkg::ST_SEGS_WAIT: if (status.div_done) cmd.op = ecnd_pkg::OP_SEGS_GET;
         ecnd_pkg::ST_TGT_LO:    cmd.op = ecnd_pkg::OP_TGT_LO;
         ecnd_pkg::ST_TGT_HI:    cmd.op = ecnd_pkg::OP_TGT_HI;
         ecnd_pkg::ST_TGT_SUM:   cmd.op = ecnd_pkg::OP_TGT_SUM;
         ecnd_pkg::ST_TGT_GO:    cmd.op = ecnd_pkg::OP_TGT_GO;
         ecnd_pkg::ST_TGT_WAIT:  if (status.div_done) cmd.op = ecnd_pkg::OP_TGT_GET;
         ecnd_pkg::ST_WEND:      cmd.op = ecnd_pkg::OP_NONE;
         ecnd_pkg::ST_FE_GO:     cmd.op = ecnd_pkg::OP_FE_GO;
         ecnd_pkg::ST_FE_WAIT:   if (status.div_done) cmd.op = ecnd_pkg::OP_FE_GET;
         ecnd_pkg::ST_FD_GO:     cmd.op = ecnd_pkg::OP_FD_GO;
         ecnd_pkg::ST_FD_WAIT:   if (status.div_done) cmd.op = ecnd_pkg::OP_FD_GET;
         ecnd_pkg::ST_EA_MUL:    cmd.op = ecnd_pkg::OP_EA_MUL;
         ecnd_pkg::ST_EA_MUL2:   cmd.op = ecnd_pkg::OP_EA_MUL2;
         ecnd_pkg::ST_EA_SUM:    cmd.op = ecnd_pkg::OP_EA_SUM;
         ecnd_pkg::ST_EB_MUL:    cmd.op = ecnd_pkg::OP_EB_MUL;
         ecnd_pkg::ST_EB_MUL2:   cmd.op = ecnd_pkg::OP_EB_MUL2;
         ecnd_pkg::ST_EB_SUM:    cmd.op = ecnd_pkg::OP_EB_SUM;
         ecnd_pkg::ST_CUT_MUL:   cmd.op = ecnd_pkg::OP_CUT_MUL;
         ecnd_pkg::ST_CUT_SET:   cmd.op = ecnd_pkg::OP_CUT_SET;
         ecnd_pkg::ST_SS_MUL:    cmd.op = ecnd_pkg::OP_SS_MUL;
         ecnd_pkg::ST_RSP:       if (out_free) cmd.op = ecnd_pkg::OP_RSP;
         default:                cmd.op = ecnd_pkg::OP_NONE;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (cmd.op == ecnd_pkg::OP_RSP) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ecnd_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = (state_ff == ecnd_pkg::ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule
`default_nettype wire

### src/ecnd_checker.sv
`timescale 1ns / 1ps
`default_nettype none
`include "ecn_and_delay_congestion_estimator_defines.svh"
module ecnd_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_valid,
   input wire logic        req_ready,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic [31:0] rsp_cwnd_out,
   input wire logic        rsp_cwnd_reduced,
   input wire logic        rsp_window_closed,
   input wire logic [16:0] rsp_alpha_out,
   input wire logic [16:0] rsp_beta_out
);

   `ECND_ASSERT(a_rsp_hold, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_cwnd_out), "rsp beat dropped or changed while stalled")
   `ECND_ASSERT(a_cut_needs_close, rsp_valid |-> !rsp_cwnd_reduced || rsp_window_closed, "cwnd cut without a window end")
   `ECND_ASSERT(a_q16_range, rsp_valid |-> rsp_alpha_out <= 17'h10000 && rsp_beta_out <= 17'h10000, "estimate above one")
   `ECND_ASSERT(a_busy_after_accept, req_valid && req_ready |=> !req_ready, "second beat taken while busy")
   `ECND_ASSERT_ALWAYS(a_reset_empty, reset |=> !rsp_valid, "rsp valid right after reset")

endmodule

bind ecn_and_delay_congestion_estimator ecnd_checker u_chk (.*);
`default_nettype wire
